>>> rtl/hpq_pkg.sv
// hpq_pkg: shared types and codes for the max-heap priority queue.
// Used by hpq_cell and max_heap_priority_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

	localparam int DATA_W           = 32;
	localparam int DEFAULT_CAPACITY = 64;

	// operation codes on the func port
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// broadcast cell operations
	localparam logic [1:0] CELL_HOLD = 2'd0; // keep data, clear search chain
	localparam logic [1:0] CELL_SCAN = 2'd1; // advance search chain
	localparam logic [1:0] CELL_INS  = 2'd2; // open a slot and shift right
	localparam logic [1:0] CELL_DEL  = 2'd3; // close the slot and shift left

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/hpq_cell.sv
// hpq_cell: one slot of the sorted (descending) cell chain.
// Depends on hpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpq_cell (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire hpq_pkg::cmd_t                   cmd,
	input  wire                                  valid,
	input  wire                                  left_keep,
	input  wire signed [hpq_pkg::DATA_W-1:0]     left_data,
	input  wire                                  left_chain,
	input  wire signed [hpq_pkg::DATA_W-1:0]     right_data,
	output logic signed [hpq_pkg::DATA_W-1:0]    data,
	output logic                                 keep,
	output logic                                 chain
);

	logic signed [hpq_pkg::DATA_W-1:0] data_q;
	logic                              chain_q;
	logic                              le;
	logic                              hit;

	// keep: stays put on insert; le: shifts left on delete
	assign keep = valid && (data_q >= cmd.value);
	assign le   = valid && (data_q <= cmd.value);
	assign hit  = valid && (data_q == cmd.value);

	always_ff @(posedge clk) begin
		case (cmd.op)
			hpq_pkg::CELL_INS: begin
				if (!keep) begin
					data_q <= left_keep ? cmd.value : left_data;
				end
			end
			hpq_pkg::CELL_DEL: begin
				if (le) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	// match flag ripples one cell per cycle toward the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= 1'b0;
		end else if (cmd.op == hpq_pkg::CELL_SCAN) begin
			chain_q <= left_chain | hit;
		end else begin
			chain_q <= 1'b0;
		end
	end

	assign data  = data_q;
	assign chain = chain_q;

endmodule

`default_nettype wire

>>> rtl/max_heap_priority_queue.sv
// max_heap_priority_queue: top level, controller plus a chain of hpq_cell slots.
// Depends on hpq_pkg and hpq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of signed 32-bit words, returning the maximum.
// Command channel: a word (func, value) is taken on a rising edge with start
// high and busy low. func = insert or delete-one-occurrence of value.
// Result channel: done pulses for one cycle with status, count, top_valid and
// top_value; the receiver cannot stall it, so it must take every pulse.
// Storage is a row of CAPACITY cells kept sorted largest first, so the
// maximum is always cell 0. Insert: every cell compares against the value in
// the same cycle and the tail of the row shifts right by one.
// Delete: a match flag ripples one cell per cycle down the row; when the scan
// has covered the row, the tail cell knows whether the value is present, and
// the cells at or after the first match shift left by one.
// Path from start accept to done: insert passes through ST_INS; delete passes
// through ST_SRCH, whose length the ripple of the match chain sets, and ST_DEL.
// One word at a time; busy is high from accept until the result cycle, and a
// new word may be taken in the cycle done is high.
// Reset: count returns to zero at once; cell contents are not cleared since
// only slots below count are ever looked at.

module max_heap_priority_queue #(
	parameter int CAPACITY = hpq_pkg::DEFAULT_CAPACITY,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int SW = $clog2(CAPACITY)
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire                                  func,
	input  wire signed [hpq_pkg::DATA_W-1:0]     value,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [CW-1:0]                        count,
	output logic                                 top_valid,
	output logic signed [hpq_pkg::DATA_W-1:0]    top_value
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;
	localparam logic [1:0] ST_DEL  = 2'd3;

	logic [1:0]                         state_q;
	logic [SW-1:0]                      scan_q;
	logic [CW-1:0]                      count_q;
	logic signed [hpq_pkg::DATA_W-1:0]  value_q;
	logic                               done_q;
	logic [1:0]                         status_q;

	logic                               full;
	logic                               found;
	hpq_pkg::cmd_t                      cmd;

	logic signed [hpq_pkg::DATA_W-1:0]  data_w  [CAPACITY];
	logic                               keep_w  [CAPACITY];
	logic                               chain_w [CAPACITY];

	assign full  = (count_q == CW'(CAPACITY));
	assign found = chain_w[CAPACITY-1];
	assign busy  = (state_q != ST_IDLE);

	// broadcast to every cell
	always_comb begin
		cmd.value = value_q;
		case (state_q)
			ST_INS:  cmd.op = full ? hpq_pkg::CELL_HOLD : hpq_pkg::CELL_INS;
			ST_SRCH: cmd.op = hpq_pkg::CELL_SCAN;
			ST_DEL:  cmd.op = found ? hpq_pkg::CELL_DEL : hpq_pkg::CELL_HOLD;
			default: cmd.op = hpq_pkg::CELL_HOLD;
		endcase
	end

	// the row of cells; cell 0 always takes the inserted word if it moves
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               vld;
		logic                               lk;
		logic signed [hpq_pkg::DATA_W-1:0]  ld;
		logic                               lc;
		logic signed [hpq_pkg::DATA_W-1:0]  rd;

		assign vld = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign ld = '0;
			assign lc = 1'b0;
		end else begin : g_body
			assign lk = keep_w[i-1];
			assign ld = data_w[i-1];
			assign lc = chain_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rd = data_w[i];
		end else begin : g_inner
			assign rd = data_w[i+1];
		end

		hpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.valid      (vld),
			.left_keep  (lk),
			.left_data  (ld),
			.left_chain (lc),
			.right_data (rd),
			.data       (data_w[i]),
			.keep       (keep_w[i]),
			.chain      (chain_w[i])
		);
	end

	// operand word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_q <= value;
		end
	end

	// sequencer, count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= hpq_pkg::STATUS_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (start) begin
						state_q <= (func == hpq_pkg::FUNC_DELETE) ? ST_SRCH : ST_INS;
					end
				end
				ST_INS: begin
					if (full) begin
						status_q <= hpq_pkg::STATUS_FULL;
					end else begin
						status_q <= hpq_pkg::STATUS_OK;
						count_q  <= count_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SRCH: begin
					// stay here while the match chain ripples to the tail
					scan_q <= scan_q + SW'(1);
					if (scan_q == SW'(CAPACITY - 1)) begin
						state_q <= ST_DEL;
					end
				end
				ST_DEL: begin
					if (found) begin
						status_q <= hpq_pkg::STATUS_OK;
						count_q  <= count_q - CW'(1);
					end else begin
						status_q <= hpq_pkg::STATUS_NOT_FOUND;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign count     = count_q;
	assign top_valid = (count_q != '0);
	assign top_value = (count_q != '0) ? data_w[0] : '0;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == hpq_pkg::STATUS_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full status with room left");

	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == hpq_pkg::STATUS_NOT_FOUND) |-> (count_q == $past(count_q)))
		else $error("failed delete changed the count");

	a_srch_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |=> (state_q == ST_SRCH || state_q == ST_DEL))
		else $error("search left early");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_INS || $past(state_q) == ST_DEL))
		else $error("result without a finishing step");
`endif

endmodule

`default_nettype wire

>>> bench/max_heap_priority_queue_tb.sv
// max_heap_priority_queue_tb: self-checking bench for the bounded max-heap queue.
// Drives insert/delete words on the start/busy port and checks every done strobe
// against a behavioral heap kept in the bench. Depends on hpq_pkg and the RTL top.
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

	localparam int DATA_W     = hpq_pkg::DATA_W;
	localparam int CAPACITY   = 64;
	localparam int CW         = $clog2(CAPACITY + 1);
	localparam int RAND_ITEMS = 1800;
	// last stretch of the random part runs back to back, no sender gaps
	localparam int TAIL_QUIET = 150;
	localparam int NUM_DIR    = 25;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	// one result word as it appears on the done strobe
	typedef struct packed {
		logic [1:0]               status;
		logic [CW-1:0]            count;
		logic                     top_valid;
		logic signed [DATA_W-1:0] top_value;
	} heap_result_t;

	// directed row: the word, and optionally a hand-written expected result
	typedef struct packed {
		logic                     f;
		logic signed [DATA_W-1:0] v;
		logic                     typed;
		heap_result_t             want;
	} dir_row_t;

	typedef enum {MODE_FILL, MODE_EMPTY, MODE_MIXED} phase_mode_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic                     func      = hpq_pkg::FUNC_INSERT;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     busy;
	logic                     done;
	logic [1:0]               status;
	logic [CW-1:0]            count;
	logic                     top_valid;
	logic signed [DATA_W-1:0] top_value;

	// bench copy of the heap: array store plus fill level
	logic signed [DATA_W-1:0] pq_store [CAPACITY];
	int unsigned              pq_size = 0;

	// results still owed by the block, oldest first
	heap_result_t             pending_results [$];
	heap_result_t             oldest_exp;

	int unsigned errors   = 0;
	int unsigned n_ins    = 0;
	int unsigned n_del    = 0;
	int unsigned n_full   = 0;
	int unsigned n_miss   = 0;
	int unsigned n_drains = 0;
	int unsigned peak     = 0;
	int unsigned n_checked = 0;

	// Directed words. Rows with typed = 1 carry a result that is obvious by
	// inspection (empty heap, extremes, misses); the rest use the heap model.
	dir_row_t directed_rows [NUM_DIR] = '{
		'{hpq_pkg::FUNC_DELETE, 32'sd5, 1'b1, '{hpq_pkg::STATUS_NOT_FOUND, CW'(0), 1'b0, 32'sd0}},
		'{hpq_pkg::FUNC_INSERT, VAL_MAX, 1'b1, '{hpq_pkg::STATUS_OK, CW'(1), 1'b1, VAL_MAX}},
		'{hpq_pkg::FUNC_INSERT, VAL_MIN, 1'b1, '{hpq_pkg::STATUS_OK, CW'(2), 1'b1, VAL_MAX}},
		'{hpq_pkg::FUNC_DELETE, 32'sd0, 1'b1, '{hpq_pkg::STATUS_NOT_FOUND, CW'(2), 1'b1, VAL_MAX}},
		'{hpq_pkg::FUNC_DELETE, VAL_MAX, 1'b1, '{hpq_pkg::STATUS_OK, CW'(1), 1'b1, VAL_MIN}},
		'{hpq_pkg::FUNC_DELETE, VAL_MIN, 1'b1, '{hpq_pkg::STATUS_OK, CW'(0), 1'b0, 32'sd0}},
		'{hpq_pkg::FUNC_INSERT, 32'sd0, 1'b1, '{hpq_pkg::STATUS_OK, CW'(1), 1'b1, 32'sd0}},
		'{hpq_pkg::FUNC_INSERT, -32'sd1, 1'b1, '{hpq_pkg::STATUS_OK, CW'(2), 1'b1, 32'sd0}},
		'{hpq_pkg::FUNC_INSERT, 32'sd1, 1'b1, '{hpq_pkg::STATUS_OK, CW'(3), 1'b1, 32'sd1}},
		'{hpq_pkg::FUNC_DELETE, 32'sd1, 1'b1, '{hpq_pkg::STATUS_OK, CW'(2), 1'b1, 32'sd0}},
		'{hpq_pkg::FUNC_INSERT, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, -32'sd3,    1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, 32'sd10,    1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, -32'sd3,    1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, 32'sh5555_5555, 1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, 32'shAAAA_AAAA, 1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sh5555_5555, 1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sd10,    1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sd7,     1'b0, '0},
		'{hpq_pkg::FUNC_DELETE, 32'sd100,   1'b0, '0},
		'{hpq_pkg::FUNC_INSERT, -32'sd1,    1'b0, '0}
	};

	max_heap_priority_queue #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.value    (value),
		.done     (done),
		.status   (status),
		.count    (count),
		.top_valid(top_valid),
		.top_value(top_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Heap model
	// ---------------------------------------------------------------

	// move entry toward the root while it beats its parent; returns final slot
	function automatic int unsigned raise_entry(input int unsigned idx);
		int unsigned              i;
		int unsigned              p;
		logic signed [DATA_W-1:0] t;
		i = idx;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (pq_store[i] <= pq_store[p])
				break;
			t           = pq_store[i];
			pq_store[i] = pq_store[p];
			pq_store[p] = t;
			i           = p;
		end
		return i;
	endfunction

	// move entry toward the leaves; left child wins ties, stop unless a child
	// is strictly larger
	function automatic void lower_entry(input int unsigned idx);
		int unsigned              i;
		int unsigned              l;
		int unsigned              best;
		logic signed [DATA_W-1:0] t;
		i = idx;
		while (i < pq_size) begin
			l    = 2 * i + 1;
			best = i;
			if (l < pq_size && pq_store[l] > pq_store[best])
				best = l;
			if (l + 1 < pq_size && pq_store[l + 1] > pq_store[best])
				best = l + 1;
			if (best == i)
				break;
			t              = pq_store[i];
			pq_store[i]    = pq_store[best];
			pq_store[best] = t;
			i              = best;
		end
	endfunction

	// apply one accepted word to the bench heap and return the result it owes
	function automatic heap_result_t apply_word(input logic f,
			input logic signed [DATA_W-1:0] v);
		heap_result_t r;
		int unsigned  i;
		int unsigned  hit;
		bit           found;
		r.status = hpq_pkg::STATUS_OK;
		found    = 1'b0;
		hit      = 0;
		if (f == hpq_pkg::FUNC_INSERT) begin
			n_ins++;
			if (pq_size >= CAPACITY) begin
				r.status = hpq_pkg::STATUS_FULL;
				n_full++;
			end else begin
				pq_store[pq_size] = v;
				pq_size++;
				void'(raise_entry(pq_size - 1));
			end
		end else begin
			n_del++;
			// lowest store index wins among duplicates
			for (i = 0; i < pq_size && !found; i++) begin
				if (pq_store[i] == v) begin
					found = 1'b1;
					hit   = i;
				end
			end
			if (!found) begin
				r.status = hpq_pkg::STATUS_NOT_FOUND;
				n_miss++;
			end else begin
				pq_size--;
				// dropping the tail entry needs no repair
				if (hit < pq_size) begin
					pq_store[hit] = pq_store[pq_size];
					if (raise_entry(hit) == hit)
						lower_entry(hit);
				end
			end
		end
		if (pq_size > peak)
			peak = pq_size;
		r.count     = CW'(pq_size);
		r.top_valid = (pq_size > 0);
		r.top_value = (pq_size > 0) ? pq_store[0] : '0;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------

	// Present one word and hold it until taken. Called at a rising edge;
	// returns at the edge where start && !busy took it.
	task automatic send_word(input logic f, input logic signed [DATA_W-1:0] v,
			input logic typed, input heap_result_t want);
		heap_result_t r;
		start <= 1'b1;
		func  <= f;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = apply_word(f, v);
		if (typed)
			r = want;
		pending_results.push_back(r);
	endtask

	// sender goes quiet for a burst of length n (n >= 1)
	task automatic idle_burst(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender waits until every owed result has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		n_drains++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		// narrow range gives plenty of duplicates and hits
		if (sel < 8)
			return int'($urandom_range(0, 12)) - 6;
		if (sel < 11) begin
			case ($urandom_range(0, 6))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 32'sd0;
				3: return -32'sd1;
				4: return 32'sd1;
				5: return VAL_MIN + 32'sd1;
				default: return VAL_MAX - 32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// ---------------------------------------------------------------
	// Result checker: done cannot be stalled, so every strobe is checked
	// against the oldest owed result.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none outstanding, got status %0d count %0d",
					$time, status, count);
			end else begin
				oldest_exp = pending_results.pop_front();
				n_checked++;
				if (status !== oldest_exp.status) begin
					errors++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, oldest_exp.status, status);
				end
				if (count !== oldest_exp.count) begin
					errors++;
					$display("%0t: count mismatch, expected %0d, actual %0d",
						$time, oldest_exp.count, count);
				end
				if (top_valid !== oldest_exp.top_valid) begin
					errors++;
					$display("%0t: top_valid mismatch, expected %0d, actual %0d",
						$time, oldest_exp.top_valid, top_valid);
				end
				if (top_value !== oldest_exp.top_value) begin
					errors++;
					$display("%0t: top_value mismatch, expected %0d, actual %0d",
						$time, $signed(oldest_exp.top_value), $signed(top_value));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned              r;
		int unsigned              k;
		int unsigned              rand_sent;
		int unsigned              phase_len;
		bit                       gaps_on;
		bit                       do_ins;
		logic                     f;
		logic signed [DATA_W-1:0] v;
		phase_mode_t              mode;

		rand_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words, back to back
		for (r = 0; r < NUM_DIR; r++)
			send_word(directed_rows[r].f, directed_rows[r].v,
				directed_rows[r].typed, directed_rows[r].want);
		hold_until_drained();

		// Random part in phases: fill phases push the heap into the full
		// case, empty phases mostly delete values known to be held, mixed
		// phases churn around the middle.
		while (rand_sent < RAND_ITEMS) begin
			mode      = phase_mode_t'($urandom_range(0, 2));
			phase_len = $urandom_range(40, 150);
			gaps_on   = (rand_sent < RAND_ITEMS - TAIL_QUIET) && ($urandom_range(0, 2) != 0);
			if (gaps_on && $urandom_range(0, 3) == 0)
				hold_until_drained();
			for (k = 0; k < phase_len && rand_sent < RAND_ITEMS; k++) begin
				case (mode)
					MODE_FILL:  do_ins = ($urandom_range(0, 99) < 85);
					MODE_EMPTY: do_ins = ($urandom_range(0, 99) < 15);
					default:    do_ins = ($urandom_range(0, 99) < 50);
				endcase
				if (do_ins) begin
					f = hpq_pkg::FUNC_INSERT;
					v = pick_value();
				end else begin
					f = hpq_pkg::FUNC_DELETE;
					// mostly target a held value; the rest may miss
					if (pq_size > 0 && $urandom_range(0, 3) != 0)
						v = pq_store[$urandom_range(0, pq_size - 1)];
					else
						v = pick_value();
				end
				send_word(f, v, 1'b0, '0);
				rand_sent++;
				if (gaps_on && rand_sent < RAND_ITEMS - TAIL_QUIET
						&& $urandom_range(0, 5) == 0)
					idle_burst($urandom_range(1, 10));
			end
		end
		start <= 1'b0;

		// wait out the longest delete, then flag anything still owed
		for (k = 0; k < 4 * CAPACITY && pending_results.size() != 0; k++)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0t: %0d result words never arrived", $time, pending_results.size());
		end
		// catch stray strobes after the last expected one
		repeat (CAPACITY + 8) @(posedge clk);

		$display("Run: %0d words checked, %0d inserts (%0d refused full), %0d deletes (%0d misses)",
			n_checked, n_ins, n_full, n_del, n_miss);
		$display("Run: peak fill %0d of %0d, %0d full drains of the result pipe",
			peak, CAPACITY, n_drains);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#8_000_000;
		$display("%0t: timeout", $time);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
